>>> rtl/wsdf_pkg.sv
package wsdf_pkg;

    // Default and smallest supported width of the payload length counter
    localparam int LEN_WIDTH_DEF = 64;
    localparam int LEN_WIDTH_MIN = 16;

    // Header field masks and markers
    localparam logic [7:0] HDR_FIN_BIT  = 8'h80;
    localparam logic [7:0] HDR_RSV_BITS = 8'h40 | 8'h20 | 8'h10;
    localparam logic [3:0] OPCODE_MASK  = 4'hF;
    localparam logic [3:0] OPCODE_CLOSE = 4'h8;
    localparam logic [6:0] LEN7_EXT16   = 7'd126;
    localparam logic [6:0] LEN7_EXT64   = 7'd127;

    // Byte counts still to come in the length or key field, minus one
    localparam logic [2:0] HC_EXT16 = 3'd1;
    localparam logic [2:0] HC_EXT64 = 3'd7;
    localparam logic [2:0] HC_KEY   = 3'd3;
    localparam logic [2:0] HC_LAST  = 3'd0;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_CLOSE   = 2'd1,
        KIND_EXTERR  = 2'd2,
        KIND_EMPTY   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic       frame_end;
    } t_result;

endpackage

>>> rtl/wsdf_parse.sv
module wsdf_parse
    import wsdf_pkg::*;
#(
    parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase                 r_phase, n_phase;
    logic [3:0]             r_opcode, n_opcode;
    logic                   r_discard, n_discard;
    logic                   r_masked, n_masked;
    logic [31:0]            r_key, n_key;
    logic [LEN_WIDTH-1:0]   r_len, n_len;
    logic                   r_len_ovf, n_len_ovf;
    logic [2:0]             r_hc, n_hc;
    logic [1:0]             r_lane, n_lane;

    logic [6:0]             len7;
    logic [LEN_WIDTH-1:0]   len_shift;
    logic                   len_ovf_now;
    logic [LEN_WIDTH-1:0]   len_final;
    logic [31:0]            key_shift;
    logic [7:0]             key_byte;
    logic                   fin;
    logic                   rsv;

    // Field extraction for the header, length, mask and payload phases
    always_comb begin
        fin         = (i_rx_byte & HDR_FIN_BIT) != 8'd0;
        rsv         = (i_rx_byte & HDR_RSV_BITS) != 8'd0;
        len7        = i_rx_byte[6:0];
        len_shift   = {r_len[LEN_WIDTH-9:0], i_rx_byte};
        len_ovf_now = r_len_ovf | (r_len[LEN_WIDTH-1 -: 8] != 8'd0);
        len_final   = len_ovf_now ? {LEN_WIDTH{1'b1}} : len_shift;
        key_shift   = {r_key[23:0], i_rx_byte};
        key_byte    = r_masked ? r_key[(3 - r_lane) * 8 +: 8] : 8'd0;
    end

    // Next state and result for one received word
    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_discard   = r_discard;
        n_masked    = r_masked;
        n_key       = r_key;
        n_len       = r_len;
        n_len_ovf   = r_len_ovf;
        n_hc        = r_hc;
        n_lane      = r_lane;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, frame_end: 1'b1};

        unique case (r_phase)
            PH_HDR0: begin
                n_opcode = i_rx_byte[3:0] & OPCODE_MASK;
                n_phase  = PH_HDR1;
                n_key    = 32'd0;
                n_lane   = 2'd0;
                if (!fin) begin
                    n_discard = 1'b1;
                end else if (rsv) begin
                    n_discard   = 1'b1;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_EXTERR;
                end else if ((i_rx_byte[3:0] & OPCODE_MASK) == OPCODE_CLOSE) begin
                    n_discard   = 1'b1;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_CLOSE;
                end else begin
                    n_discard = 1'b0;
                end
            end
            PH_HDR1: begin
                n_masked  = i_rx_byte[7];
                n_len     = '0;
                n_len_ovf = 1'b0;
                n_lane    = 2'd0;
                if (len7 == LEN7_EXT16) begin
                    n_phase = PH_EXTLEN;
                    n_hc    = HC_EXT16;
                end else if (len7 == LEN7_EXT64) begin
                    n_phase = PH_EXTLEN;
                    n_hc    = HC_EXT64;
                end else begin
                    n_len = LEN_WIDTH'(len7);
                    if (i_rx_byte[7]) begin
                        n_phase = PH_MASK;
                        n_hc    = HC_KEY;
                        n_key   = 32'd0;
                    end else if (len7 == 7'd0) begin
                        n_phase     = PH_HDR0;
                        o_res_valid = !r_discard;
                        o_res.kind  = KIND_EMPTY;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_EXTLEN: begin
                n_len     = len_shift;
                n_len_ovf = len_ovf_now;
                if (r_hc == HC_LAST) begin
                    // Saturate lengths beyond the counter range
                    n_len  = len_final;
                    n_lane = 2'd0;
                    if (r_masked) begin
                        n_phase = PH_MASK;
                        n_hc    = HC_KEY;
                        n_key   = 32'd0;
                    end else if (len_final == '0) begin
                        n_phase     = PH_HDR0;
                        o_res_valid = !r_discard;
                        o_res.kind  = KIND_EMPTY;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_hc = r_hc - 3'd1;
                end
            end
            PH_MASK: begin
                n_key = key_shift;
                if (r_hc == HC_LAST) begin
                    n_lane = 2'd0;
                    if (r_len == '0) begin
                        n_phase     = PH_HDR0;
                        o_res_valid = !r_discard;
                        o_res.kind  = KIND_EMPTY;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_hc = r_hc - 3'd1;
                end
            end
            PH_PAYLOAD: begin
                // Unmask, count down, close the frame on its last word
                n_lane = r_lane + 2'd1;
                n_len  = r_len - LEN_WIDTH'(1);
                if (r_len == LEN_WIDTH'(1)) begin
                    n_phase = PH_HDR0;
                end
                o_res_valid        = !r_discard;
                o_res.kind         = KIND_PAYLOAD;
                o_res.payload_byte = i_rx_byte ^ key_byte;
                o_res.frame_end    = (r_len == LEN_WIDTH'(1));
            end
            default: begin
                n_phase = PH_HDR0;
            end
        endcase
    end

    // Advance parser state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR0;
            r_opcode  <= 4'd0;
            r_discard <= 1'b0;
            r_masked  <= 1'b0;
            r_key     <= 32'd0;
            r_len     <= '0;
            r_len_ovf <= 1'b0;
            r_hc      <= 3'd0;
            r_lane    <= 2'd0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_opcode  <= n_opcode;
            r_discard <= n_discard;
            r_masked  <= n_masked;
            r_key     <= n_key;
            r_len     <= n_len;
            r_len_ovf <= n_len_ovf;
            r_hc      <= n_hc;
            r_lane    <= n_lane;
        end
    end

endmodule

>>> rtl/wsdf_skid.sv
module wsdf_skid
    import wsdf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_result i_in_data,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_result o_out_data,
    input  logic    i_out_stall
);

    logic    r_out_valid;
    t_result r_out_data;
    logic    r_skid_valid;
    t_result r_skid_data;
    logic    out_free;

    // Output register is free when empty or being taken this cycle
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Hold a stalled word in the skid stage, refill the output from it first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_in_valid) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload moves without reset
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_in_valid) begin
            if (out_free) begin
                r_out_data <= i_in_data;
            end else begin
                r_skid_data <= i_in_data;
            end
        end
    end

endmodule

>>> rtl/websocket_frame_deframer_core.sv
// WebSocket frame deframer, receive side after the opening handshake.
// Input channel: one stream byte per word on i_rx_byte, moved by i_valid
// and o_stall. Output channel: o_kind, o_payload_byte, o_frame_end, moved
// by o_valid and i_stall. Kinds are payload byte, close frame, extension
// error and empty frame; o_frame_end marks the last payload byte of a frame
// and every non-payload result.
// Throughput: one input word per cycle while o_stall is low. Header bytes
// give a result only for a close, an extension error or an empty frame;
// bytes of skipped frames give none. Each result is registered in the
// output register behind the parser and shown on o_valid from there.
// When the receiver stalls, the result holds on the outputs and one more
// result is taken into a skid stage; o_stall then rises until it drains.
// Reset (synchronous, active low) returns the parser to the first header
// byte and empties both output stages.
module websocket_frame_deframer_core
    import wsdf_pkg::*;
#(
    parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_payload_byte,
    output logic       o_frame_end
);

    logic    take;
    logic    res_valid;
    t_result res;
    t_result out_data;

    assign take = i_valid && !o_stall;

    wsdf_parse #(
        .LEN_WIDTH(LEN_WIDTH)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_rx_byte  (i_rx_byte),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    wsdf_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (take && res_valid),
        .i_in_data  (res),
        .o_in_stall (o_stall),
        .o_out_valid(o_valid),
        .o_out_data (out_data),
        .i_out_stall(i_stall)
    );

    assign o_kind         = out_data.kind;
    assign o_payload_byte = out_data.payload_byte;
    assign o_frame_end    = out_data.frame_end;

endmodule

>>> rtl/wsdf_checker.sv
module wsdf_checker
    import wsdf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_kind,
    input logic [7:0] o_payload_byte,
    input logic       o_frame_end
);

    // Non-payload results always close a frame
    a_ctrl_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_PAYLOAD) |-> o_frame_end)
        else $error("non-payload result without frame end");

    // Non-payload results carry a zero data byte
    a_ctrl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_PAYLOAD) |-> (o_payload_byte == 8'd0))
        else $error("non-payload result with nonzero byte");

    // Input stall only follows a stalled output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && $past(i_rst_n)) |-> $past(o_valid && i_stall))
        else $error("input stalled without output backpressure");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_kind)
            && $stable(o_payload_byte) && $stable(o_frame_end)))
        else $error("stalled result changed");

endmodule

bind websocket_frame_deframer_core wsdf_checker u_wsdf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_kind        (o_kind),
    .o_payload_byte(o_payload_byte),
    .o_frame_end   (o_frame_end)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import wsdf_pkg::*;

    // Encodings of the payload length in the second header byte
    typedef enum int {
        LEN_FORM7,
        LEN_FORM16,
        LEN_FORM64
    } t_len_form;

    localparam logic [63:0] LEN_CAP      = {64{1'b1}} >> (64 - LEN_WIDTH_DEF);
    localparam int          STALL_LIMIT  = 2000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_payload_byte;
    logic       o_frame_end;

    // Shadow of the parser state
    t_phase      ph = PH_HDR0;
    logic [3:0]  cur_opcode = 4'h0;
    logic        skip_frame = 1'b0;
    logic        frame_masked = 1'b0;
    logic [31:0] key_word = 32'h0;
    logic [63:0] len_left = 64'h0;
    logic [2:0]  hdr_left = 3'd0;
    logic [1:0]  key_lane = 2'd0;

    t_result     pending_results[$];
    t_result     head_result;
    int          mismatch_count = 0;
    int          rx_words = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          no_idle = 1'b0;

    websocket_frame_deframer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_frame_end    (o_frame_end)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic void queue_result(t_kind k, logic [7:0] v, logic e);
        t_result r;
        r.kind         = k;
        r.payload_byte = v;
        r.frame_end    = e;
        pending_results.push_back(r);
    endfunction

    // Header complete: empty frame or on to the payload
    function automatic void close_header();
        key_lane = 2'd0;
        if (len_left == 64'd0) begin
            ph = PH_HDR0;
            if (!skip_frame) queue_result(KIND_EMPTY, 8'h00, 1'b1);
        end else begin
            ph = PH_PAYLOAD;
        end
    endfunction

    // Length known: clamp it, then fetch the key if the frame is masked
    function automatic void close_length();
        if (len_left > LEN_CAP) len_left = LEN_CAP;
        if (frame_masked) begin
            ph       = PH_MASK;
            hdr_left = HC_KEY;
            key_word = 32'h0;
        end else begin
            close_header();
        end
    endfunction

    // Advance the shadow parser by one stream byte, queue what it yields
    function automatic void parse_rx_byte(logic [7:0] b);
        logic [7:0] key_byte;
        unique case (ph)
            PH_HDR0: begin
                cur_opcode = b[3:0] & OPCODE_MASK;
                ph         = PH_HDR1;
                key_word   = 32'h0;
                key_lane   = 2'd0;
                if ((b & HDR_FIN_BIT) == 8'h00) begin
                    skip_frame = 1'b1;
                end else if ((b & HDR_RSV_BITS) != 8'h00) begin
                    skip_frame = 1'b1;
                    queue_result(KIND_EXTERR, 8'h00, 1'b1);
                end else if (cur_opcode == OPCODE_CLOSE) begin
                    skip_frame = 1'b1;
                    queue_result(KIND_CLOSE, 8'h00, 1'b1);
                end else begin
                    skip_frame = 1'b0;
                end
            end
            PH_HDR1: begin
                frame_masked = b[7];
                len_left     = 64'd0;
                if (b[6:0] == LEN7_EXT16) begin
                    ph       = PH_EXTLEN;
                    hdr_left = HC_EXT16;
                end else if (b[6:0] == LEN7_EXT64) begin
                    ph       = PH_EXTLEN;
                    hdr_left = HC_EXT64;
                end else begin
                    len_left = {57'd0, b[6:0]};
                    close_length();
                end
            end
            PH_EXTLEN: begin
                len_left = {len_left[55:0], b};
                if (hdr_left == HC_LAST) close_length();
                else hdr_left = hdr_left - 3'd1;
            end
            PH_MASK: begin
                key_word = {key_word[23:0], b};
                if (hdr_left == HC_LAST) close_header();
                else hdr_left = hdr_left - 3'd1;
            end
            PH_PAYLOAD: begin
                key_byte = frame_masked ? key_word[8 * (3 - key_lane) +: 8] : 8'h00;
                key_lane = key_lane + 2'd1;
                if (len_left != 64'd0) len_left = len_left - 64'd1;
                if (len_left == 64'd0) ph = PH_HDR0;
                if (!skip_frame) queue_result(KIND_PAYLOAD, b ^ key_byte, len_left == 64'd0);
            end
            default: ph = PH_HDR0;
        endcase
    endfunction

    // Offer one word after an optional gap, hold it until taken
    task automatic push_rx_byte(input logic [7:0] b);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        rx_words++;
        parse_rx_byte(b);
    endtask

    // Hold the input idle until every queued result has drained
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic send_frame(input logic [7:0] b0, input bit msk, input t_len_form form,
                              input logic [63:0] len, input int unsigned body);
        logic [31:0] key;
        int unsigned i;
        key = $urandom;
        push_rx_byte(b0);
        case (form)
            LEN_FORM7: begin
                push_rx_byte({msk, len[6:0]});
            end
            LEN_FORM16: begin
                push_rx_byte({msk, LEN7_EXT16});
                push_rx_byte(len[15:8]);
                push_rx_byte(len[7:0]);
            end
            default: begin
                push_rx_byte({msk, LEN7_EXT64});
                for (i = 0; i < 8; i++) push_rx_byte(len[63 - 8 * i -: 8]);
            end
        endcase
        if (msk) begin
            for (i = 0; i < 4; i++) push_rx_byte(key[31 - 8 * i -: 8]);
        end
        for (i = 0; i < body; i++) push_rx_byte(8'($urandom));
    endtask

    // Well-formed frames with random header bits, lengths and payload
    task automatic send_random_frame();
        logic [7:0]  b0;
        logic [63:0] len;
        t_len_form   form;
        bit          msk;
        int unsigned r;
        b0[7]   = ($urandom_range(0, 9) != 0);
        b0[6:4] = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
        b0[3:0] = ($urandom_range(0, 7) == 0) ? OPCODE_CLOSE : 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) == 0) b0 = 8'($urandom);
        msk  = ($urandom_range(0, 9) < 7);
        form = LEN_FORM7;
        r    = $urandom_range(0, 99);
        if (r < 10) begin
            len = 64'd0;
        end else if (r < 75) begin
            len = 64'($urandom_range(1, 12));
        end else if (r < 85) begin
            len = 64'($urandom_range(13, 125));
        end else if (r < 93) begin
            form = LEN_FORM16;
            len  = 64'($urandom_range(0, 300));
        end else begin
            form = LEN_FORM64;
            len  = 64'($urandom_range(0, 40));
        end
        send_frame(b0, msk, form, len, 32'(len));
    endtask

    task automatic test_empty_frames();
        send_frame(8'h81, 1'b0, LEN_FORM7, 64'd0, 0);
        send_frame(8'h01, 1'b0, LEN_FORM7, 64'd0, 0);
        send_frame(8'h82, 1'b1, LEN_FORM7, 64'd0, 0);
    endtask

    task automatic test_control_frames();
        // close with a payload: one close result, payload dropped
        send_frame(8'h88, 1'b1, LEN_FORM7, 64'd2, 2);
        // reserved bits win over the close opcode
        send_frame(8'hF8, 1'b0, LEN_FORM7, 64'd1, 1);
    endtask

    task automatic test_extended_lengths();
        send_frame(8'h89, 1'b0, LEN_FORM16, 64'd0, 0);
        send_frame(8'h8A, 1'b1, LEN_FORM64, 64'd2, 2);
        send_frame(8'h00, 1'b0, LEN_FORM7, 64'd3, 3);
    endtask

    task automatic test_random_traffic(input int n);
        int target;
        target = rx_words + n;
        while (rx_words < target) send_random_frame();
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            send_random_frame();
            send_random_frame();
            drain_results();
        end
    endtask

    task automatic test_back_to_back(input int n);
        no_idle = 1'b1;
        test_random_traffic(n);
        no_idle = 1'b0;
    endtask

    // 64-bit length with every bit set; the stream ends mid-payload
    task automatic test_unterminated_frame();
        send_frame(8'h82, 1'b1, LEN_FORM64, {64{1'b1}}, 12);
    endtask

    // Receive side: check each accepted word, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: kind %0d byte %0h end %0d",
                           o_kind, o_payload_byte, o_frame_end);
                    mismatch_count++;
                end else begin
                    head_result = pending_results.pop_front();
                    if (o_kind !== head_result.kind) begin
                        $error("kind: expected %0d, got %0d", head_result.kind, o_kind);
                        mismatch_count++;
                    end
                    if (o_payload_byte !== head_result.payload_byte) begin
                        $error("payload_byte: expected %0h, got %0h",
                               head_result.payload_byte, o_payload_byte);
                        mismatch_count++;
                    end
                    if (o_frame_end !== head_result.frame_end) begin
                        $error("frame_end: expected %0d, got %0d",
                               head_result.frame_end, o_frame_end);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left != 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                stall_left = idle_len();
            end
        end
    end

    // Stop a hung run: too many cycles without any word moving
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("websocket_frame_deframer_core verification failed");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_frames();
        test_control_frames();
        test_extended_lengths();
        test_random_traffic(600);
        test_drain_pause();
        test_back_to_back(400);
        test_random_traffic(250);
        test_unterminated_frame();
        drain_results();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("websocket_frame_deframer_core verification clean");
        end else begin
            if (pending_results.size() != 0)
                $error("%0d expected results never arrived", pending_results.size());
            $display("websocket_frame_deframer_core verification failed");
        end
        $finish;
    end

endmodule
